// ===== rtl/block_map_index_decompose_macros.svh =====
// Assertion macros shared by the block map index decomposition RTL.
`ifndef BLOCK_MAP_INDEX_DECOMPOSE_MACROS_SVH
`define BLOCK_MAP_INDEX_DECOMPOSE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BMID_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BMID_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bmid_pkg.sv =====
// Package with constants and types for the block map index decomposition.
package bmid_pkg;

    localparam int unsigned OffsetW        = 32;
    localparam int unsigned LogBsW         = 3;
    localparam int unsigned LevelW         = 2;
    localparam int unsigned SlotW          = 4;
    localparam int unsigned IndexW         = 14;
    localparam int unsigned InBlkW         = 16;
    localparam int unsigned BlockShiftBase = 10;
    localparam int unsigned TableShiftBase = 8;
    localparam int unsigned FblockW        = OffsetW - BlockShiftBase;
    localparam int unsigned BoundW         = 30;
    localparam int unsigned ShiftW         = 5;
    localparam int unsigned DirectSlots    = 12;
    localparam logic [LogBsW-1:0] MaxLogBs = 3'd6;

    typedef enum logic [LevelW-1:0] {
        LVL_DIRECT = 2'd0,
        LVL_SINGLE = 2'd1,
        LVL_DOUBLE = 2'd2,
        LVL_TRIPLE = 2'd3
    } level_t;

endpackage

// ===== rtl/block_map_index_decompose.sv =====
// Top level of the block map index decomposition: file offset to table indices.
// Throughput: one word per cycle while m_ready keeps up. A word passes through an
// input register and a result register, the only stages, with a shift, a mask and
// three subtract-and-compare paths between them.
// Reset: aresetn is synchronous and active low; it empties both stages and sets
// the block size select to 0 (1 KiB blocks). The configuration port is always ready.
`include "block_map_index_decompose_macros.svh"

module block_map_index_decompose (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bmid_pkg::LogBsW-1:0]         cfg_bsize_log,
    // Input word channel.
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [bmid_pkg::OffsetW-1:0]        s_byte_pos,
    // Result word channel.
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [bmid_pkg::LevelW-1:0]         m_level,
    output logic [bmid_pkg::SlotW-1:0]          m_inode_slot,
    output logic [bmid_pkg::IndexW-1:0]         m_top_index,
    output logic [bmid_pkg::IndexW-1:0]         m_mid_index,
    output logic [bmid_pkg::IndexW-1:0]         m_leaf_index,
    output logic [bmid_pkg::InBlkW-1:0]         m_byte_in_blk
);

    // The configuration register must only be changed while the pipeline is empty (the
    // block does not enforce this), so the decode stage reads it directly.
    logic [bmid_pkg::LogBsW-1:0]  log_bs_reg;

    // Input stage.
    logic                         in_valid_reg;
    logic                         in_valid_next;
    logic [bmid_pkg::OffsetW-1:0] in_off_reg;

    // Result stage.
    logic                         m_valid_reg;
    logic                         m_valid_next;
    bmid_pkg::level_t             level_reg;
    bmid_pkg::level_t             level_next;
    logic [bmid_pkg::SlotW-1:0]   slot_reg;
    logic [bmid_pkg::SlotW-1:0]   slot_next;
    logic [bmid_pkg::IndexW-1:0]  top_reg;
    logic [bmid_pkg::IndexW-1:0]  top_next;
    logic [bmid_pkg::IndexW-1:0]  mid_reg;
    logic [bmid_pkg::IndexW-1:0]  mid_next;
    logic [bmid_pkg::IndexW-1:0]  leaf_reg;
    logic [bmid_pkg::IndexW-1:0]  leaf_next;
    logic [bmid_pkg::InBlkW-1:0]  inblk_reg;
    logic [bmid_pkg::InBlkW-1:0]  inblk_next;

    // Handshake control.
    logic                         out_free;
    logic                         in_take;
    logic                         move;

    // Decode datapath.
    logic [bmid_pkg::LogBsW-1:0]  log_eff;
    logic [bmid_pkg::ShiftW-1:0]  blk_shift;
    logic [bmid_pkg::ShiftW-1:0]  tbits;
    logic [bmid_pkg::ShiftW-1:0]  tbits2;
    logic [bmid_pkg::OffsetW-1:0] shifted;
    logic [bmid_pkg::OffsetW-1:0] blk_mask;
    logic [bmid_pkg::OffsetW-1:0] inblk_full;
    logic [bmid_pkg::FblockW-1:0] fblock;
    logic [bmid_pkg::BoundW-1:0]  fblock_w;
    logic [bmid_pkg::BoundW-1:0]  bound1;
    logic [bmid_pkg::BoundW-1:0]  bound2;
    logic [bmid_pkg::BoundW-1:0]  rank2_w;
    logic [bmid_pkg::BoundW-1:0]  rank3_w;
    logic [bmid_pkg::FblockW-1:0] rank1;
    logic [bmid_pkg::FblockW-1:0] rank2;
    logic [bmid_pkg::FblockW-1:0] rank3;
    logic [bmid_pkg::FblockW-1:0] tmask;
    logic [bmid_pkg::FblockW-1:0] r2_hi;
    logic [bmid_pkg::FblockW-1:0] r3_hi;
    logic [bmid_pkg::FblockW-1:0] r3_mid;

    // The result register frees up when it is empty or its word is taken this cycle.
    // The input register can then hand its word on, so a new word enters every cycle
    // as long as the consumer keeps up.
    assign out_free  = !m_valid_reg || m_ready;
    assign move      = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign in_take   = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign in_valid_next = in_take || (in_valid_reg && !out_free);
    assign m_valid_next  = move || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            log_bs_reg   <= '0;
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                log_bs_reg <= cfg_bsize_log;
            end
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_off_reg <= s_byte_pos;
        end
        if (move) begin
            level_reg <= level_next;
            slot_reg  <= slot_next;
            top_reg   <= top_next;
            mid_reg   <= mid_next;
            leaf_reg  <= leaf_next;
            inblk_reg <= inblk_next;
        end
    end

    // Decode. A register value of seven saturates to six, the largest block size whose
    // table indices fit the 14-bit index fields. The level boundaries are built 30 bits
    // wide, enough for twelve direct blocks plus single and double ranges at the
    // largest table size, so no boundary wraps.
    always_comb begin
        log_eff    = (log_bs_reg > bmid_pkg::MaxLogBs) ? bmid_pkg::MaxLogBs : log_bs_reg;
        blk_shift  = bmid_pkg::ShiftW'(bmid_pkg::BlockShiftBase) + bmid_pkg::ShiftW'(log_eff);
        tbits      = bmid_pkg::ShiftW'(bmid_pkg::TableShiftBase) + bmid_pkg::ShiftW'(log_eff);
        tbits2     = {tbits[bmid_pkg::ShiftW-2:0], 1'b0};

        shifted    = in_off_reg >> blk_shift;
        fblock     = shifted[bmid_pkg::FblockW-1:0];
        blk_mask   = (bmid_pkg::OffsetW'(1) << blk_shift) - bmid_pkg::OffsetW'(1);
        inblk_full = in_off_reg & blk_mask;
        inblk_next = inblk_full[bmid_pkg::InBlkW-1:0];

        fblock_w   = bmid_pkg::BoundW'(fblock);
        bound1     = bmid_pkg::BoundW'(bmid_pkg::DirectSlots)
                   + (bmid_pkg::BoundW'(1) << tbits);
        bound2     = bound1 + (bmid_pkg::BoundW'(1) << tbits2);

        rank1      = fblock - bmid_pkg::FblockW'(bmid_pkg::DirectSlots);
        rank2_w    = fblock_w - bound1;
        rank3_w    = fblock_w - bound2;
        rank2      = rank2_w[bmid_pkg::FblockW-1:0];
        rank3      = rank3_w[bmid_pkg::FblockW-1:0];

        tmask      = (bmid_pkg::FblockW'(1) << tbits) - bmid_pkg::FblockW'(1);
        r2_hi      = (rank2 >> tbits) & tmask;
        r3_hi      = (rank3 >> tbits2) & tmask;
        r3_mid     = (rank3 >> tbits) & tmask;

        top_next   = '0;
        mid_next   = '0;
        leaf_next  = '0;

        if (fblock_w < bmid_pkg::BoundW'(bmid_pkg::DirectSlots)) begin
            level_next = bmid_pkg::LVL_DIRECT;
        end else if (fblock_w < bound1) begin
            level_next = bmid_pkg::LVL_SINGLE;
            top_next   = rank1[bmid_pkg::IndexW-1:0] & tmask[bmid_pkg::IndexW-1:0];
        end else if (fblock_w < bound2) begin
            level_next = bmid_pkg::LVL_DOUBLE;
            top_next   = r2_hi[bmid_pkg::IndexW-1:0];
            mid_next   = rank2[bmid_pkg::IndexW-1:0] & tmask[bmid_pkg::IndexW-1:0];
        end else begin
            level_next = bmid_pkg::LVL_TRIPLE;
            top_next   = r3_hi[bmid_pkg::IndexW-1:0];
            mid_next   = r3_mid[bmid_pkg::IndexW-1:0];
            leaf_next  = rank3[bmid_pkg::IndexW-1:0] & tmask[bmid_pkg::IndexW-1:0];
        end

        // Direct blocks use their own number as the slot; indirect levels start at
        // the slot just past the direct ones.
        if (level_next == bmid_pkg::LVL_DIRECT) begin
            slot_next = fblock[bmid_pkg::SlotW-1:0];
        end else begin
            slot_next = bmid_pkg::SlotW'(bmid_pkg::DirectSlots - 1)
                      + bmid_pkg::SlotW'(level_next);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_level       = level_reg;
    assign m_inode_slot  = slot_reg;
    assign m_top_index   = top_reg;
    assign m_mid_index   = mid_reg;
    assign m_leaf_index  = leaf_reg;
    assign m_byte_in_blk = inblk_reg;

    // A direct result never carries table indices and stays below the indirect slots.
    `BMID_ASSERT_SAME(a_direct_clean, aclk, aresetn, m_valid_reg && (level_reg == bmid_pkg::LVL_DIRECT), (top_reg == '0) && (mid_reg == '0) && (leaf_reg == '0) && (slot_reg < bmid_pkg::SlotW'(bmid_pkg::DirectSlots)), "direct result with nonzero index or bad slot")

    // An indirect result points at the slot of its level.
    `BMID_ASSERT_SAME(a_indirect_slot, aclk, aresetn, m_valid_reg && (level_reg != bmid_pkg::LVL_DIRECT), slot_reg == (bmid_pkg::SlotW'(bmid_pkg::DirectSlots - 1) + bmid_pkg::SlotW'(level_reg)), "indirect result with wrong inode slot")

    // Only triple indirection walks a third table.
    `BMID_ASSERT_SAME(a_leaf_unused, aclk, aresetn, m_valid_reg && (level_reg != bmid_pkg::LVL_TRIPLE), leaf_reg == '0, "leaf index set below triple indirection")

    // An accepted word occupies the input stage in the next cycle.
    `BMID_ASSERT_NEXT(a_take_holds, aclk, aresetn, s_valid && s_ready, in_valid_reg, "accepted word lost from input stage")

endmodule

// ===== tb/sv/tb_block_map_index_decompose.sv =====
// Self-checking testbench for the block map index decomposition block.
module tb_block_map_index_decompose;
    import bmid_pkg::*;

    // Cycles without any accepted word before the run is declared hung.
    localparam int unsigned WatchdogLimit    = 4000;
    // Extra cycles after the last expected word, to catch stray result words.
    localparam int unsigned SettleCycles     = 8;
    localparam int unsigned MaxReports       = 40;
    localparam int unsigned RandomPerSetting = 78;
    localparam int unsigned LongHoldCycles   = 80;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_RANDOM,
        RDY_PATTERN
    } ready_mode_t;

    // One decomposed result word, laid out like the m_ payload.
    typedef struct packed {
        level_t              level;
        logic [SlotW-1:0]    inode_slot;
        logic [IndexW-1:0]   top_index;
        logic [IndexW-1:0]   mid_index;
        logic [IndexW-1:0]   leaf_index;
        logic [InBlkW-1:0]   byte_in_blk;
    } decomp_t;

    // A pending lookup keeps its offset so that a mismatch line can name it.
    typedef struct packed {
        logic [OffsetW-1:0]  byte_pos;
        decomp_t             result;
    } lookup_t;

    logic                  aclk               = 1'b0;
    logic                  aresetn            = 1'b0;
    logic                  cfg_valid          = 1'b0;
    logic                  cfg_ready;
    logic [LogBsW-1:0]     cfg_bsize_log      = '0;
    logic                  s_valid            = 1'b0;
    logic                  s_ready;
    logic [OffsetW-1:0]    s_byte_pos         = '0;
    logic                  m_valid;
    logic                  m_ready            = 1'b0;
    logic [LevelW-1:0]     m_level;
    logic [SlotW-1:0]      m_inode_slot;
    logic [IndexW-1:0]     m_top_index;
    logic [IndexW-1:0]     m_mid_index;
    logic [IndexW-1:0]     m_leaf_index;
    logic [InBlkW-1:0]     m_byte_in_blk;

    // Lookups accepted on s_ whose result word has not come back yet, oldest first.
    lookup_t               pending_lookups[$];
    // Our copy of the block size register, updated when a write is accepted.
    logic [LogBsW-1:0]     log_bs_shadow      = '0;
    int unsigned           mismatch_count     = 0;

    // Sender burst control.
    int unsigned           burst_left         = 0;
    bit                    sender_gaps        = 1'b1;

    // Receiver control. A long hold is requested by bumping hold_req; the
    // receiver process notices the change and counts the hold down itself.
    ready_mode_t           ready_mode         = RDY_ALWAYS;
    logic [15:0]           ready_pattern      = 16'b1101_1001_1110_0110;
    int unsigned           hold_req           = 0;
    int unsigned           hold_seen          = 0;
    int unsigned           hold_len           = 0;
    int unsigned           hold_left          = 0;

    block_map_index_decompose DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_bsize_log      (cfg_bsize_log),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_byte_pos         (s_byte_pos),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_level            (m_level),
        .m_inode_slot       (m_inode_slot),
        .m_top_index        (m_top_index),
        .m_mid_index        (m_mid_index),
        .m_leaf_index       (m_leaf_index),
        .m_byte_in_blk      (m_byte_in_blk)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // The register value seven would make tables wider than the index
    // fields, so it behaves like six.
    function automatic int unsigned eff_log(input logic [LogBsW-1:0] log_bs);
        int unsigned l;
        l = 32'(log_bs);
        if (l > 32'(MaxLogBs)) l = 32'(MaxLogBs);
        return l;
    endfunction

    // First file block number of indirection level lvl (1, 2 or 3). The sums
    // are kept at 64 bits, so they never wrap for large blocks.
    function automatic logic [63:0] level_start(input logic [LogBsW-1:0] log_bs,
                                                input int unsigned lvl);
        int unsigned tbits;
        logic [63:0] tsize;
        logic [63:0] start;
        tbits = TableShiftBase + eff_log(log_bs);
        tsize = 64'd1 << tbits;
        start = 64'(DirectSlots);
        if (lvl >= 2) start = start + tsize;
        if (lvl >= 3) start = start + (tsize << tbits);
        return start;
    endfunction

    // Base-T digit number pos of the rank inside a level, T = 2**tbits.
    function automatic logic [IndexW-1:0] table_digit(input logic [63:0] rank,
                                                      input int unsigned pos,
                                                      input int unsigned tbits);
        logic [63:0] digit;
        digit = (rank >> (pos * tbits)) & ((64'd1 << tbits) - 64'd1);
        return digit[IndexW-1:0];
    endfunction

    function automatic decomp_t decompose_offset(input logic [OffsetW-1:0] off,
                                                 input logic [LogBsW-1:0] log_bs);
        int unsigned shift;
        int unsigned tbits;
        int unsigned slot;
        logic [63:0] fblock;
        logic [63:0] inblk;
        logic [63:0] rank;
        decomp_t r;
        shift  = BlockShiftBase + eff_log(log_bs);
        tbits  = TableShiftBase + eff_log(log_bs);
        fblock = {32'd0, off} >> shift;
        inblk  = {32'd0, off} & ((64'd1 << shift) - 64'd1);
        r = '0;
        r.byte_in_blk = inblk[InBlkW-1:0];
        if (fblock < level_start(log_bs, 1)) begin
            // Direct block: the slot is the block number itself.
            r.level      = LVL_DIRECT;
            r.inode_slot = fblock[SlotW-1:0];
        end else if (fblock < level_start(log_bs, 2)) begin
            r.level     = LVL_SINGLE;
            rank        = fblock - level_start(log_bs, 1);
            r.top_index = table_digit(rank, 0, tbits);
        end else if (fblock < level_start(log_bs, 3)) begin
            r.level     = LVL_DOUBLE;
            rank        = fblock - level_start(log_bs, 2);
            r.top_index = table_digit(rank, 1, tbits);
            r.mid_index = table_digit(rank, 0, tbits);
        end else begin
            r.level      = LVL_TRIPLE;
            rank         = fblock - level_start(log_bs, 3);
            r.top_index  = table_digit(rank, 2, tbits);
            r.mid_index  = table_digit(rank, 1, tbits);
            r.leaf_index = table_digit(rank, 0, tbits);
        end
        if (r.level != LVL_DIRECT) begin
            // Indirect levels start from inode slots 12, 13 and 14.
            slot = DirectSlots - 1 + 32'(r.level);
            r.inode_slot = slot[SlotW-1:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Random offsets that favor the level boundaries, the first and last
    // blocks and the first and last byte of a block; the rest are uniform.
    function automatic logic [OffsetW-1:0] pick_offset(input logic [LogBsW-1:0] log_bs);
        int unsigned shift;
        logic [63:0] fmax;
        logic [63:0] anchor;
        logic [63:0] step;
        logic [63:0] blk;
        logic [63:0] byte_mask;
        logic [63:0] pos;
        shift     = BlockShiftBase + eff_log(log_bs);
        fmax      = 64'hFFFF_FFFF >> shift;
        byte_mask = (64'd1 << shift) - 64'd1;
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom();
            3:       anchor = 64'd0;
            4:       anchor = level_start(log_bs, 1);
            5:       anchor = level_start(log_bs, 2);
            6:       anchor = level_start(log_bs, 3);
            7:       anchor = fmax;
            default: anchor = {32'd0, $urandom()} % (level_start(log_bs, 2) + 64'd1);
        endcase
        step = 64'($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 1) blk = anchor + step;
        else blk = (anchor >= step) ? anchor - step : 64'd0;
        if (blk > fmax) blk = fmax;
        case ($urandom_range(0, 3))
            0:       pos = blk << shift;
            1:       pos = (blk << shift) | byte_mask;
            default: pos = (blk << shift) | ({32'd0, $urandom()} & byte_mask);
        endcase
        return pos[OffsetW-1:0];
    endfunction

    // Sends one offset word. The sender runs in bursts of random length; when
    // gaps are enabled, a random number of idle cycles precedes each burst.
    // The expected result is queued at the edge where the word is accepted.
    task automatic send_offset(input logic [OffsetW-1:0] off);
        int unsigned gap;
        lookup_t entry;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = sender_gaps ? $urandom_range(0, 5) : 0;
            repeat (gap) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        burst_left--;
        s_valid    <= 1'b1;
        s_byte_pos <= off;
        do @(posedge aclk); while (!s_ready);
        entry.byte_pos = off;
        entry.result   = decompose_offset(off, log_bs_shadow);
        pending_lookups.push_back(entry);
    endtask

    // Drops valid and waits until every expected result word has arrived.
    // It always waits on the clock before returning, so a following send never
    // changes s_valid twice in one time step.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_lookups.size() != 0) @(posedge aclk);
    endtask

    // Register writes happen only with the pipeline empty. Every input word
    // produces a result word, so an empty queue means the block is idle.
    task automatic write_bsize_log(input logic [LogBsW-1:0] value);
        wait_for_results();
        cfg_valid     <= 1'b1;
        cfg_bsize_log <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid     <= 1'b0;
        log_bs_shadow  = value;
    endtask

    // Offset zero, the last byte before and the first byte of each level
    // that the block size can reach, and the largest offset.
    task automatic sweep_level_edges();
        int unsigned shift;
        logic [63:0] fmax;
        logic [63:0] b;
        logic [63:0] pos;
        shift = BlockShiftBase + eff_log(log_bs_shadow);
        fmax  = 64'hFFFF_FFFF >> shift;
        send_offset('0);
        for (int unsigned lvl = 1; lvl <= 3; lvl++) begin
            b = level_start(log_bs_shadow, lvl);
            if (b <= fmax) begin
                pos = (b << shift) - 64'd1;
                send_offset(pos[OffsetW-1:0]);
                pos = b << shift;
                send_offset(pos[OffsetW-1:0]);
            end
        end
        send_offset('1);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // With the reset block size (1 KiB) every level is reachable. This phase
    // runs with no idling on either side.
    task automatic test_reset_setting_edges();
        sender_gaps = 1'b0;
        ready_mode  = RDY_ALWAYS;
        sweep_level_edges();
    endtask

    // Largest block size, where the level breaks would overflow at 32 bits,
    // and the saturated register value seven, which must match six.
    task automatic test_largest_and_saturated_edges();
        sender_gaps = 1'b1;
        ready_mode  = RDY_RANDOM;
        write_bsize_log(3'd6);
        sweep_level_edges();
        write_bsize_log(3'd7);
        sweep_level_edges();
    endtask

    // Random offsets under every register value, rotating the receiver
    // patterns. One setting runs without any sender gaps.
    task automatic test_random_offsets();
        logic [LogBsW-1:0] order [0:7];
        order = '{3'd3, 3'd1, 3'd5, 3'd0, 3'd2, 3'd4, 3'd6, 3'd7};
        for (int i = 0; i < 8; i++) begin
            write_bsize_log(order[i]);
            sender_gaps = (i != 3);
            ready_mode  = ready_mode_t'(i % 3);
            repeat (RandomPerSetting) send_offset(pick_offset(log_bs_shadow));
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering words back to back, so the block fills and stalls s_.
    task automatic test_result_backpressure();
        write_bsize_log(3'd0);
        sender_gaps = 1'b0;
        ready_mode  = RDY_ALWAYS;
        hold_len    = LongHoldCycles;
        hold_req++;
        repeat (40) send_offset(pick_offset(log_bs_shadow));
    endtask

    // The sender stops in the middle of a stream until every result word
    // has come back, then resumes.
    task automatic test_sender_pause();
        write_bsize_log(3'd1);
        sender_gaps = 1'b1;
        ready_mode  = RDY_PATTERN;
        repeat (20) send_offset(pick_offset(log_bs_shadow));
        wait_for_results();
        repeat (20) send_offset(pick_offset(log_bs_shadow));
    endtask

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------

    // m_ready follows the selected mode unless a long hold is running.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= hold_len;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            case (ready_mode)
                RDY_ALWAYS: m_ready <= 1'b1;
                RDY_RANDOM: m_ready <= ($urandom_range(0, 3) != 0);
                default: begin
                    m_ready       <= ready_pattern[0];
                    ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
                end
            endcase
        end
    end

    task automatic report_mismatch(input string what, input logic [OffsetW-1:0] off,
                                   input logic [31:0] got, input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MaxReports)
            $display("ERROR %s: offset 0x%08h bsize_log %0d got 0x%0h expected 0x%0h",
                     what, off, log_bs_shadow, got, want);
    endtask

    // Every accepted result word is compared with the oldest pending lookup.
    always @(posedge aclk) begin : check_result_word
        lookup_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_lookups.size() == 0) begin
                report_mismatch("result word with nothing pending", '0, 32'(m_level),
                                32'd0);
            end else begin
                want = pending_lookups.pop_front();
                if (m_level !== want.result.level)
                    report_mismatch("level", want.byte_pos, 32'(m_level),
                                    32'(want.result.level));
                if (m_inode_slot !== want.result.inode_slot)
                    report_mismatch("inode_slot", want.byte_pos, 32'(m_inode_slot),
                                    32'(want.result.inode_slot));
                if (m_top_index !== want.result.top_index)
                    report_mismatch("top_index", want.byte_pos, 32'(m_top_index),
                                    32'(want.result.top_index));
                if (m_mid_index !== want.result.mid_index)
                    report_mismatch("mid_index", want.byte_pos, 32'(m_mid_index),
                                    32'(want.result.mid_index));
                if (m_leaf_index !== want.result.leaf_index)
                    report_mismatch("leaf_index", want.byte_pos, 32'(m_leaf_index),
                                    32'(want.result.leaf_index));
                if (m_byte_in_blk !== want.result.byte_in_blk)
                    report_mismatch("byte_in_blk", want.byte_pos, 32'(m_byte_in_blk),
                                    32'(want.result.byte_in_blk));
            end
        end
    end

    // The watchdog ends the run if no word moves on any channel for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WatchdogLimit) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("block_map_index_decompose: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        // Reset is held low at the start and released at a rising edge.
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_setting_edges();
        test_largest_and_saturated_edges();
        test_random_offsets();
        test_result_backpressure();
        test_sender_pause();

        // Drain, then wait SettleCycles for any stray result word to show up.
        wait_for_results();
        repeat (SettleCycles) @(posedge aclk);
        if (mismatch_count == 0)
            $display("block_map_index_decompose: match");
        else
            $display("block_map_index_decompose: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bmid_pkg.sv
rtl/block_map_index_decompose.sv
tb/sv/tb_block_map_index_decompose.sv
